>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, codes and types for the bitmap block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   // Fixed field widths of the request, response and register beats.
   localparam int OPCODE_W = 2;
   localparam int BLOCK_W  = 12;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 13;

   // Register reset value and default geometry.
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
   localparam int DEF_MAX_BLOCKS = 4096;
   localparam int DEF_WORD_BITS  = 32;

   // Request operations.
   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RESERVE = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WALK,
      S_MODIFY
   } state_type;

endpackage : bba_pkg

`default_nettype wire

>>> rtl/bba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one registered read port; a row that was never written
// since reset reads as all zero, so every block starts free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_bitmap_ram
   import bba_pkg::*;
#(
   parameter int WORDS     = 128,
   parameter int WORD_BITS = 32,
   parameter int AW        = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [WORD_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORDS-1:0]     row_valid_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_row_valid_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // One valid flag per row, cleared together at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff    <= '0;
         rd_row_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_row_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // A row that has not been written yet holds only free blocks.
   assign rd_data = rd_row_valid_ff ? rd_word_ff : '0;

endmodule : bba_bitmap_ram

`default_nettype wire

>>> rtl/bba_first_free.sv
// ----------------------------------------------------------------------------
// First free bit finder
// Finds the lowest clear bit of one bitmap word among the bits that still lie
// below the block limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_first_free
   import bba_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int SW        = 5,
   parameter int CW        = 13
) (
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic [CW-1:0]        remain,
   output logic                      found,
   output logic      [SW-1:0]        index
);

   logic [WORD_BITS-1:0] candidate;

   // A bit is a candidate when it is clear and its block is below the limit.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         candidate[i] = !word[i] && (CW'(i) < remain);
      end
   end

   // Priority encoder: the lowest candidate wins.
   always_comb begin
      found = |candidate;
      index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (candidate[i]) begin
            index = SW'(i);
         end
      end
   end

endmodule : bba_first_free

`default_nettype wire

>>> rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a used/free bitmap held in a word memory. One
// sequencer drives a shared base adder and compare through the words.
//
//   Channel   Direction  Handshake                 Beat
//   request   in         start high, busy low      req_opcode, req_block_number
//   response  out        rsp_valid one-cycle pulse rsp_allocated_block, rsp_status
//   register  in         csr_valid and csr_ready   csr_data (total_blocks)
//
// Allocate reads one bitmap word per cycle through the single read port. Free
// and reserve slice the word index and bit offset straight out of the block
// number (WORD_BITS is a power of two), read that word and write it back. An
// out-of-range block or a no-op is answered from idle, with no memory access.
// The register takes a beat only while the block is idle and no request is
// offered in the same cycle.
// Reset clears the row valid flags at once; no clearing sweep is needed.
// The response is a strobe and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = DEF_WORD_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [BLOCK_W-1:0]  req_block_number,
   output logic                     rsp_valid,
   output logic      [BLOCK_W-1:0]  rsp_allocated_block,
   output logic      [STATUS_W-1:0] rsp_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [TOTAL_W-1:0]  csr_data
);

   localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int SPAN  = WORDS * WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int NEED  = $clog2(SPAN + WORD_BITS + 1);
   localparam int CW    = (NEED > TOTAL_W) ? NEED : TOTAL_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [CW-1:0]        blk_ff, blk_in;
   logic [CW-1:0]        base_ff, base_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 issued_all_ff, issued_all_in;
   logic                 dv_ff, dv_in;
   logic [CW-1:0]        dbase_ff, dbase_in;
   logic [AW-1:0]        daddr_ff, daddr_in;
   logic                 dlast_ff, dlast_in;
   logic [SW-1:0]        bitoff_ff, bitoff_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]   rsp_block_ff, rsp_block_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 accept;
   opcode_type           req_op;
   logic [CW-1:0]        req_blk;
   logic [CW-1:0]        limit;
   logic [CW-1:0]        base_next;
   logic [CW-1:0]        remain;
   logic                 free_found;
   logic [SW-1:0]        free_index;
   logic [CW-1:0]        granted;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] bit_mask;

   // Handshakes. A register beat never shares an edge with a request beat.
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy && !start;
   assign req_op    = opcode_type'(req_opcode);
   assign req_blk   = CW'(req_block_number);

   // Block limit, saturated to the bitmap size.
   assign limit = (CW'(total_ff) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(total_ff);

   // Shared word-base adder, used by the scan.
   assign base_next = base_ff + CW'(WORD_BITS);

   // Blocks of the returned word still below the limit, and the granted number.
   assign remain  = limit - dbase_ff;
   assign granted = dbase_ff + CW'(free_index);

   assign bit_mask = WORD_BITS'(1) << bitoff_ff;

   bba_bitmap_ram #(
      .WORDS     (WORDS),
      .WORD_BITS (WORD_BITS),
      .AW        (AW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bba_first_free #(
      .WORD_BITS (WORD_BITS),
      .SW        (SW),
      .CW        (CW)
   ) u_first_free (
      .word   (rd_data),
      .remain (remain),
      .found  (free_found),
      .index  (free_index)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      base_ff       <= base_in;
      addr_ff       <= addr_in;
      issued_all_ff <= issued_all_in;
      dbase_ff      <= dbase_in;
      daddr_ff      <= daddr_in;
      dlast_ff      <= dlast_in;
      bitoff_ff     <= bitoff_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Sequencer: next state, memory port and response.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      issued_all_in = issued_all_ff;
      dv_in         = 1'b0;
      dbase_in      = dbase_ff;
      daddr_in      = daddr_ff;
      dlast_in      = dlast_ff;
      bitoff_in     = bitoff_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = daddr_ff;
      wr_data       = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               total_in = csr_data;
            end
            if (accept) begin
               op_in         = req_op;
               blk_in        = req_blk;
               base_in       = '0;
               addr_in       = '0;
               issued_all_in = 1'b0;
               unique case (req_op)
                  OP_ALLOC: begin
                     state_in = S_SCAN;
                  end
                  OP_FREE, OP_RESERVE: begin
                     if (req_blk >= limit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_block_in  = '0;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_NOP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_block_in  = '0;
                     rsp_status_in = ST_OK;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue the next word read while the previous word is examined.
            if (!issued_all_ff) begin
               rd_en         = 1'b1;
               dv_in         = 1'b1;
               dbase_in      = base_ff;
               daddr_in      = addr_ff;
               dlast_in      = (addr_ff == LAST_ADDR);
               issued_all_in = (addr_ff == LAST_ADDR);
               addr_in       = addr_ff + AW'(1);
               base_in       = base_next;
            end
            if (dv_ff) begin
               if (dbase_ff >= limit) begin
                  state_in      = S_IDLE;
                  dv_in         = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_block_in  = '0;
                  rsp_status_in = ST_FULL;
               end else if (free_found) begin
                  state_in      = S_IDLE;
                  dv_in         = 1'b0;
                  wr_en         = 1'b1;
                  wr_addr       = daddr_ff;
                  wr_data       = rd_data | (WORD_BITS'(1) << free_index);
                  rsp_valid_in  = 1'b1;
                  rsp_block_in  = granted[BLOCK_W-1:0];
                  rsp_status_in = ST_OK;
               end else if (dlast_ff) begin
                  state_in      = S_IDLE;
                  dv_in         = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_block_in  = '0;
                  rsp_status_in = ST_FULL;
               end
            end
         end

         S_WALK: begin
            // Read the word that holds the named block; its index and the bit
            // offset are slices of the block number.
            rd_en     = 1'b1;
            rd_addr   = AW'(blk_ff >> SW);
            daddr_in  = AW'(blk_ff >> SW);
            bitoff_in = SW'(blk_ff);
            state_in  = S_MODIFY;
         end

         S_MODIFY: begin
            // Read-modify-write of the target word.
            wr_en         = 1'b1;
            wr_addr       = daddr_ff;
            wr_data       = (op_ff == OP_RESERVE) ? (rd_data | bit_mask)
                                                  : (rd_data & ~bit_mask);
            rsp_valid_in  = 1'b1;
            rsp_block_in  = '0;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response outputs.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_block_ff;
   assign rsp_status          = rsp_status_ff;

endmodule : bitmap_block_allocator

`default_nettype wire

>>> bench/bba_checker.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches the request, response and register channels of the allocator. It
// keeps its own copy of the usage bitmap and the block count, works out the
// grant for every accepted request beat and compares each response beat,
// field by field, with the oldest grant still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_checker
   import bba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [BLOCK_W-1:0]  req_block_number,
   input  logic                rsp_valid,
   input  logic [BLOCK_W-1:0]  rsp_allocated_block,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [TOTAL_W-1:0]  csr_data,
   output int                  fail_count,
   output int                  outstanding
);

   localparam int MAP_WORDS = DEF_MAX_BLOCKS / DEF_WORD_BITS;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [BLOCK_W-1:0] block;
      status_type         status;
   } grant_type;

   // Shadow of the block's state and its one register.
   logic [DEF_WORD_BITS-1:0] usage_map [MAP_WORDS];
   logic [TOTAL_W-1:0]       managed_blocks;
   grant_type                pending_grants [$];
   int                       error_count = 0;

   // Applies one request to the shadow bitmap and returns the grant it earns.
   function automatic grant_type next_grant(opcode_type op, logic [BLOCK_W-1:0] blk);
      grant_type g;
      int        limit;
      g.block  = '0;
      g.status = ST_OK;
      // Counts above the bitmap size saturate to the bitmap size.
      limit = (managed_blocks > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(managed_blocks);
      case (op)
         OP_ALLOC: begin
            g.status = ST_FULL;
            for (int b = 0; b < limit && g.status == ST_FULL; b++) begin
               if (!usage_map[b / DEF_WORD_BITS][b % DEF_WORD_BITS]) begin
                  usage_map[b / DEF_WORD_BITS][b % DEF_WORD_BITS] = 1'b1;
                  g.block  = BLOCK_W'(b);
                  g.status = ST_OK;
               end
            end
         end
         OP_FREE, OP_RESERVE: begin
            if (int'(blk) >= limit) begin
               g.status = ST_RANGE;
            end else begin
               usage_map[blk / DEF_WORD_BITS][blk % DEF_WORD_BITS] = (op == OP_RESERVE);
            end
         end
         default: begin
            // A no-op leaves the bitmap alone and answers with zeros.
         end
      endcase
      return g;
   endfunction

   // Counts a failure and reports the first few of them.
   function automatic void log_fault(string what, grant_type want);
      if (error_count < REPORT_MAX) begin
         $display("%0t: %s: expected block %0d status %0d, got block %0d status %0d",
                  $realtime, what, want.block, want.status, rsp_allocated_block,
                  rsp_status);
      end
      error_count++;
   endfunction

   // Request beats are taken before response beats within one edge, so a
   // response never overtakes the grant it belongs to.
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         foreach (usage_map[i]) usage_map[i] = '0;
         managed_blocks = TOTAL_RESET;
         pending_grants.delete();
      end else begin
         if (csr_valid && csr_ready) managed_blocks = csr_data;
         if (start && !busy) begin
            pending_grants.push_back(next_grant(opcode_type'(req_opcode), req_block_number));
         end
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               want = '0;
               log_fault("response beat with no request waiting", want);
            end else begin
               want = pending_grants.pop_front();
               if (want.block !== rsp_allocated_block || want.status !== rsp_status) begin
                  log_fault("response mismatch", want);
               end
            end
         end
      end
      fail_count  <= error_count;
      outstanding <= pending_grants.size();
   end

endmodule : bba_checker

>>> bench/tb_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate, free, reserve and no-op requests into the allocator under
// a series of block counts, from zero up to the saturating maximum. A short
// directed run covers the corner cases; random phases follow, with random
// gaps between request beats. A separate checker predicts every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS   = 200;
   localparam int NEAR_FRONT    = 256;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode = OP_NOP;
   logic [BLOCK_W-1:0]  req_block_number = '0;
   logic                rsp_valid;
   logic [BLOCK_W-1:0]  rsp_allocated_block;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TOTAL_W-1:0]  csr_data = '0;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   bit no_gaps = 1'b0;

   bitmap_block_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   bba_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Presents one request beat and returns at the edge that accepts it.
   // Start is left high so that a following beat can go out back to back.
   task automatic send_request(opcode_type op, logic [BLOCK_W-1:0] blk);
      req_opcode       <= op;
      req_block_number <= blk;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Holds requests off until every outstanding response beat has arrived.
   task automatic pause_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Writes the block count; only called while the allocator is idle.
   task automatic write_total(logic [TOTAL_W-1:0] total);
      csr_data  <= total;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Picks a block number: mostly inside the managed range, often near the
   // allocation front, and sometimes anywhere in the field.
   function automatic logic [BLOCK_W-1:0] pick_block(int limit);
      int roll;
      roll = $urandom_range(0, 9);
      if (limit > 0 && roll < 4) begin
         return BLOCK_W'($urandom_range(0, ((limit < NEAR_FRONT) ? limit : NEAR_FRONT) - 1));
      end else if (limit > 0 && roll < 7) begin
         return BLOCK_W'($urandom_range(0, limit - 1));
      end
      return BLOCK_W'($urandom_range(0, (1 << BLOCK_W) - 1));
   endfunction

   // One random phase under a given block count and share of allocates.
   task automatic run_phase(logic [TOTAL_W-1:0] total, int items, int alloc_pct);
      int         limit;
      int         roll;
      int         gap;
      opcode_type op;
      pause_until_drained();
      write_total(total);
      limit = (total > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(total);
      for (int n = 0; n < items; n++) begin
         // Now and then a stretch of back-to-back beats.
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct) begin
            op = OP_ALLOC;
         end else if (roll < 90) begin
            op = ($urandom_range(0, 4) < 3) ? OP_FREE : OP_RESERVE;
         end else begin
            op = OP_NOP;
         end
         send_request(op, pick_block(limit));
         if ($urandom_range(0, 39) == 0) begin
            pause_until_drained();
         end else if (!no_gaps) begin
            gap = $urandom_range(0, 19);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: first fit, reuse of a freed block, the top block, repeated
      // free and reserve, no-ops and a word boundary, at the reset count.
      send_request(OP_ALLOC, '1);
      send_request(OP_ALLOC, '0);
      send_request(OP_RESERVE, 12'd2);
      send_request(OP_ALLOC, 12'd0);
      send_request(OP_FREE, 12'd0);
      send_request(OP_ALLOC, 12'd0);
      send_request(OP_RESERVE, 12'd4095);
      send_request(OP_RESERVE, 12'd4095);
      send_request(OP_FREE, 12'd4095);
      send_request(OP_FREE, 12'd4095);
      send_request(OP_NOP, '1);
      send_request(OP_NOP, '0);
      send_request(OP_FREE, 12'd31);
      send_request(OP_RESERVE, 12'd32);

      // A single managed block: full when used, range errors above it.
      pause_until_drained();
      write_total(13'd1);
      send_request(OP_ALLOC, '0);
      send_request(OP_RESERVE, 12'd1);
      send_request(OP_FREE, 12'd0);
      send_request(OP_ALLOC, '0);

      // No managed block at all.
      pause_until_drained();
      write_total(13'd0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 12'd0);
      send_request(OP_RESERVE, 12'd4095);

      // Count above the bitmap size saturates.
      pause_until_drained();
      write_total('1);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 12'd4095);

      // Count lowered below blocks in use: nothing left to grant.
      pause_until_drained();
      write_total(13'd3);
      send_request(OP_ALLOC, '0);

      // Random phases across a spread of block counts.
      run_phase(TOTAL_RESET, PHASE_ITEMS, 45);
      run_phase(13'd40, PHASE_ITEMS, 50);
      run_phase(13'd2, PHASE_ITEMS, 45);
      run_phase(13'd1000, PHASE_ITEMS, 40);
      run_phase('1, PHASE_ITEMS, 45);
      run_phase(13'd0, PHASE_ITEMS, 30);
      run_phase(13'd33, PHASE_ITEMS, 55);
      run_phase(TOTAL_W'($urandom_range(1, DEF_MAX_BLOCKS)), PHASE_ITEMS, 45);
      run_phase(TOTAL_RESET, PHASE_ITEMS, 80);

      // Let the last responses land, then allow for any stray beat.
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : tb_bitmap_block_allocator
